// File: design/lcca_pkg.sv
// ----------------------------------------------------------------------------
// lcca_pkg - shared definitions for the load cell calibrated averager
// Widths, register indexes, reset values and the controller/datapath types.
// ----------------------------------------------------------------------------
package lcca_pkg;

    // Sample counter width; the sums grow with it.
    localparam int COUNT_WIDTH = 20;

    localparam int RAW_W      = 24;
    localparam int ELAPSED_W  = 16;
    localparam int WORD_W     = 32;
    localparam int RSUM_W     = RAW_W + COUNT_WIDTH;
    localparam int WSUM_W     = WORD_W + COUNT_WIDTH;
    localparam int DELTA_W    = WORD_W + 1;

    // Divider dividend magnitude: covers delta * 2^24, raw_sum * 2^8,
    // weight_sum and the scaled percent difference.
    localparam int NUM_W      = (COUNT_WIDTH + 32 > 56) ? COUNT_WIDTH + 32 : 56;
    localparam int DEN_W      = 32;
    localparam int DIV_CNT_W  = $clog2(NUM_W);

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 128;

    localparam int CFG_IDX_W  = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_OFFSET      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_POSITIVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_NEGATIVE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_SECONDS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFERENCE_WEIGHT = 3'd4;

    localparam logic [31:0] RST_ZERO_OFFSET      = 32'd106251056;
    localparam logic [31:0] RST_SLOPE_POSITIVE   = 32'd13667655;
    localparam logic [31:0] RST_SLOPE_NEGATIVE   = 32'd13736560;
    localparam logic [5:0]  RST_RUN_SECONDS      = 6'd60;
    localparam logic [31:0] RST_REFERENCE_WEIGHT = 32'd0;

    localparam logic [5:0]  MAX_RUN_SECONDS = 6'd60;
    localparam logic [5:0]  MIN_RUN_SECONDS = 6'd1;
    localparam logic [15:0] MS_PER_SECOND   = 16'd1000;
    localparam logic [39:0] PERCENT_SCALE   = 40'd100;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_W_START,
        S_W_WAIT,
        S_AR_START,
        S_AR_WAIT,
        S_AW_START,
        S_AW_WAIT,
        S_PCT_PREP,
        S_PCT_START,
        S_PCT_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DIV_WEIGHT,
        DIV_ARAW,
        DIV_AW,
        DIV_PCT
    } t_div_sel;

    typedef struct packed {
        logic     capture;
        logic     clear;
        logic     eval;
        logic     div_start;
        logic     div_store;
        t_div_sel div_sel;
        logic     pct_prep;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic finished;
        logic done;
        logic ref_zero;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// File: design/lcca_div.sv
// ----------------------------------------------------------------------------
// lcca_div - shared restoring divider
// One quotient bit per cycle, sign applied and result saturated to 32 bits.
// ----------------------------------------------------------------------------
module lcca_div import lcca_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_neg,
    input  logic [NUM_W-1:0]  i_mag,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [WORD_W-1:0] o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_den;
    logic [DEN_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_nq;

    logic [DEN_W:0]       shifted;
    logic [DEN_W+1:0]     trial;
    logic                 pos_ovf;
    logic                 neg_ovf;

    assign shifted = {r_rem, r_nq[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Shift the dividend out at the top, the quotient in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_neg;
            r_den <= i_den;
            r_rem <= '0;
            r_nq  <= i_mag;
        end else if (r_busy) begin
            r_rem <= trial[DEN_W+1] ? shifted[DEN_W-1:0] : trial[DEN_W-1:0];
            r_nq  <= {r_nq[NUM_W-2:0], ~trial[DEN_W+1]};
        end
    end

    assign pos_ovf = |r_nq[NUM_W-1:31];
    assign neg_ovf = (|r_nq[NUM_W-1:32]) || (r_nq[31] && (|r_nq[30:0]));

    always_comb begin
        if (r_neg) begin
            o_quot = neg_ovf ? SAT_MIN : (~r_nq[31:0] + 32'd1);
        end else begin
            o_quot = pos_ovf ? SAT_MAX : r_nq[31:0];
        end
    end

    assign o_done = r_done;

endmodule

// File: design/lcca_dp.sv
// ----------------------------------------------------------------------------
// lcca_dp - datapath of the load cell calibrated averager
// Configuration registers, run sums, operand selection, output register.
// ----------------------------------------------------------------------------
module lcca_dp import lcca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data,
    input  logic                  i_in_op,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    output logic                  o_m_valid,
    input  logic                  i_m_ready,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic                  o_m_last,
    output logic                  o_m_user
);

    // configuration
    logic [31:0]            r_zero_offset;
    logic [31:0]            r_slope_pos;
    logic [31:0]            r_slope_neg;
    logic [5:0]             r_run_secs;
    logic [31:0]            r_ref_weight;

    // captured item and per-item results
    logic                   r_op;
    logic [RAW_W-1:0]       r_raw;
    logic [ELAPSED_W-1:0]   r_elapsed;
    logic [DELTA_W-1:0]     r_delta;
    logic                   r_done;
    logic [WORD_W-1:0]      r_weight;
    logic [WORD_W-1:0]      r_avg_raw;
    logic [WORD_W-1:0]      r_avg_w;
    logic [WORD_W-1:0]      r_pct;
    logic                   r_undef;
    logic [WORD_W-1:0]      r_diff_mag;
    logic                   r_pct_neg;

    // run state
    logic [COUNT_WIDTH-1:0] r_count;
    logic [RSUM_W-1:0]      r_raw_sum;
    logic [WSUM_W-1:0]      r_weight_sum;
    logic                   r_finished;

    // output register
    logic                   r_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data;
    logic                   r_m_last;
    logic                   r_m_user;

    logic [5:0]             secs;
    logic [15:0]            run_limit;
    logic                   sample_done;
    logic                   ref_zero;
    logic [WORD_W-1:0]      ref_mag;
    logic [WORD_W-1:0]      avg_mag;
    logic [WORD_W:0]        diff;
    logic [DELTA_W-1:0]     delta_neg;
    logic [WORD_W-1:0]      delta_mag;
    logic [31:0]            slope_sel;
    logic [RSUM_W-1:0]      rsum_mag;
    logic [WSUM_W-1:0]      wsum_mag;
    logic [DEN_W-1:0]       count_den;
    logic [39:0]            pct_prod;

    logic                   div_neg;
    logic [NUM_W-1:0]       div_mag;
    logic [DEN_W-1:0]       div_den;
    logic                   div_done;
    logic [WORD_W-1:0]      div_quot;

    // Clamp the run length to one..sixty seconds.
    always_comb begin
        if (r_run_secs == 6'd0) begin
            secs = MIN_RUN_SECONDS;
        end else if (r_run_secs > MAX_RUN_SECONDS) begin
            secs = MAX_RUN_SECONDS;
        end else begin
            secs = r_run_secs;
        end
    end

    assign run_limit   = 16'(secs) * MS_PER_SECOND;
    assign sample_done = (r_elapsed >= run_limit);
    assign ref_zero    = (r_ref_weight == 32'd0);
    assign ref_mag     = r_ref_weight[31] ? (~r_ref_weight + 32'd1) : r_ref_weight;
    assign avg_mag     = r_avg_w[31] ? (~r_avg_w + 32'd1) : r_avg_w;
    assign diff        = {1'b0, avg_mag} - {1'b0, ref_mag};

    assign delta_neg   = ~r_delta + DELTA_W'(1);
    assign delta_mag   = r_delta[DELTA_W-1] ? delta_neg[WORD_W-1:0] : r_delta[WORD_W-1:0];
    assign slope_sel   = r_delta[DELTA_W-1] ? r_slope_neg : r_slope_pos;
    assign rsum_mag    = r_raw_sum[RSUM_W-1] ? (~r_raw_sum + RSUM_W'(1)) : r_raw_sum;
    assign wsum_mag    = r_weight_sum[WSUM_W-1] ? (~r_weight_sum + WSUM_W'(1))
                                                : r_weight_sum;
    assign count_den   = (r_count == '0) ? DEN_W'(1) : DEN_W'(r_count);
    assign pct_prod    = 40'(r_diff_mag) * PERCENT_SCALE;

    // Operand selection for the shared divider.
    always_comb begin
        case (i_cmd.div_sel)
            DIV_WEIGHT: begin
                div_neg = r_delta[DELTA_W-1];
                div_mag = NUM_W'(delta_mag) << 24;
                div_den = (slope_sel == 32'd0) ? DEN_W'(1) : slope_sel;
            end
            DIV_ARAW: begin
                div_neg = r_raw_sum[RSUM_W-1];
                div_mag = NUM_W'({rsum_mag, 8'h00});
                div_den = count_den;
            end
            DIV_AW: begin
                div_neg = r_weight_sum[WSUM_W-1];
                div_mag = NUM_W'(wsum_mag);
                div_den = count_den;
            end
            DIV_PCT: begin
                div_neg = r_pct_neg;
                div_mag = NUM_W'(pct_prod) << 16;
                div_den = ref_mag;
            end
            default: begin
                div_neg = 1'b0;
                div_mag = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    lcca_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_neg   (div_neg),
        .i_mag   (div_mag),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_offset <= RST_ZERO_OFFSET;
            r_slope_pos   <= RST_SLOPE_POSITIVE;
            r_slope_neg   <= RST_SLOPE_NEGATIVE;
            r_run_secs    <= RST_RUN_SECONDS;
            r_ref_weight  <= RST_REFERENCE_WEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ZERO_OFFSET:      r_zero_offset <= i_cfg_data;
                CFG_SLOPE_POSITIVE:   r_slope_pos   <= i_cfg_data;
                CFG_SLOPE_NEGATIVE:   r_slope_neg   <= i_cfg_data;
                CFG_RUN_SECONDS:      r_run_secs    <= i_cfg_data[5:0];
                CFG_REFERENCE_WEIGHT: r_ref_weight  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Run state and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_raw_sum    <= '0;
            r_weight_sum <= '0;
            r_finished   <= 1'b0;
            r_m_valid    <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count      <= '0;
                r_raw_sum    <= '0;
                r_weight_sum <= '0;
                r_finished   <= 1'b0;
            end
            if (i_cmd.div_store && (i_cmd.div_sel == DIV_WEIGHT) && (r_count != '1)) begin
                r_count      <= r_count + 1'b1;
                r_raw_sum    <= r_raw_sum + {{(RSUM_W-RAW_W){r_raw[RAW_W-1]}}, r_raw};
                r_weight_sum <= r_weight_sum
                              + {{(WSUM_W-WORD_W){div_quot[WORD_W-1]}}, div_quot};
            end
            if (i_cmd.load_out) begin
                r_m_valid <= 1'b1;
                if (r_done) begin
                    r_finished <= 1'b1;
                end
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_in_op;
            r_raw     <= i_in_data[RAW_W-1:0];
            r_elapsed <= i_in_data[RAW_W+ELAPSED_W-1:RAW_W];
        end
        if (i_cmd.eval) begin
            r_delta   <= {r_raw[RAW_W-1], r_raw, 8'h00}
                       - {r_zero_offset[31], r_zero_offset};
            r_done    <= sample_done;
            r_avg_raw <= '0;
            r_avg_w   <= '0;
            r_pct     <= '0;
            r_undef   <= sample_done && ref_zero;
        end
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                DIV_WEIGHT: r_weight  <= div_quot;
                DIV_ARAW:   r_avg_raw <= div_quot;
                DIV_AW:     r_avg_w   <= div_quot;
                DIV_PCT:    r_pct     <= div_quot;
                default: ;
            endcase
        end
        if (i_cmd.pct_prep) begin
            r_diff_mag <= diff[WORD_W] ? ~diff[WORD_W-1:0] + 32'd1 : diff[WORD_W-1:0];
            r_pct_neg  <= diff[WORD_W] ^ r_ref_weight[31];
        end
        if (i_cmd.load_out) begin
            r_m_data <= {r_pct, r_avg_w, r_avg_raw, r_weight};
            r_m_last <= r_done;
            r_m_user <= r_undef;
        end
    end

    assign o_status.op       = r_op;
    assign o_status.finished = r_finished;
    assign o_status.done     = r_done;
    assign o_status.ref_zero = ref_zero;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_m_valid || i_m_ready;

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_last  = r_m_last;
    assign o_m_user  = r_m_user;

endmodule

// File: design/lcca_ctrl.sv
// ----------------------------------------------------------------------------
// lcca_ctrl - sequencer of the load cell calibrated averager
// Steps one item through evaluation, the divisions and the output load.
// ----------------------------------------------------------------------------
module lcca_ctrl import lcca_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.op || i_status.finished) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_W_START;
                end
            end
            S_W_START: n_state = S_W_WAIT;
            S_W_WAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.done ? S_AR_START : S_OUT;
                end
            end
            S_AR_START: n_state = S_AR_WAIT;
            S_AR_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_AW_START;
                end
            end
            S_AW_START: n_state = S_AW_WAIT;
            S_AW_WAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.ref_zero ? S_OUT : S_PCT_PREP;
                end
            end
            S_PCT_PREP:  n_state = S_PCT_START;
            S_PCT_START: n_state = S_PCT_WAIT;
            S_PCT_WAIT: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
            end
            S_EVAL: begin
                o_cmd.clear = i_status.op;
                o_cmd.eval  = !i_status.op && !i_status.finished;
            end
            S_W_START: begin
                o_cmd.div_sel   = DIV_WEIGHT;
                o_cmd.div_start = 1'b1;
            end
            S_W_WAIT: begin
                o_cmd.div_sel   = DIV_WEIGHT;
                o_cmd.div_store = i_status.div_done;
            end
            S_AR_START: begin
                o_cmd.div_sel   = DIV_ARAW;
                o_cmd.div_start = 1'b1;
            end
            S_AR_WAIT: begin
                o_cmd.div_sel   = DIV_ARAW;
                o_cmd.div_store = i_status.div_done;
            end
            S_AW_START: begin
                o_cmd.div_sel   = DIV_AW;
                o_cmd.div_start = 1'b1;
            end
            S_AW_WAIT: begin
                o_cmd.div_sel   = DIV_AW;
                o_cmd.div_store = i_status.div_done;
            end
            S_PCT_PREP: begin
                o_cmd.pct_prep = 1'b1;
            end
            S_PCT_START: begin
                o_cmd.div_sel   = DIV_PCT;
                o_cmd.div_start = 1'b1;
            end
            S_PCT_WAIT: begin
                o_cmd.div_sel   = DIV_PCT;
                o_cmd.div_store = i_status.div_done;
            end
            S_OUT: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: ;
        endcase
    end

endmodule

// File: design/load_cell_calibrated_averager.sv
// ----------------------------------------------------------------------------
// load_cell_calibrated_averager - two-slope calibrated load cell averager
// Converts samples to grams, sums a run and reports averages and % error.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ----------------------------
//  s_*       in         s_tvalid / s_tready       tdata raw, elapsed; tuser op
//  m_*       out        m_tvalid / m_tready       tdata results; tlast; tuser
//  cfg       in         i_cfg_valid / o_cfg_ready index, 32-bit write data
//
//  A sample that does not end the run passes through one division; a run-ending
//  sample passes through four (three when the reference weight is zero).
//  Begin-run and ignored items go from idle to evaluate and back. All divisions
//  run on the single shared divider, which retires one quotient bit per cycle.
//  Reset is synchronous and active low; it restores the calibration defaults
//  and clears the run. A stalled m_tready holds the result in the output
//  register; the next item is still taken and waits only at its own load.
//
module load_cell_calibrated_averager import lcca_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [23:0] raw_count, [39:24] elapsed_ms
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                  s_tuser,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [31:0] weight, [63:32] average_raw, [95:64] average_weight,
    // [127:96] percent_error
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    // [0] error_undefined
    output logic                  m_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // Configuration is a plain register write: always take the transfer.
    assign o_cfg_ready = 1'b1;

    lcca_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .o_s_ready (s_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    lcca_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_op     (s_tuser),
        .i_in_data   (s_tdata),
        .o_m_valid   (m_tvalid),
        .i_m_ready   (m_tready),
        .o_m_data    (m_tdata),
        .o_m_last    (m_tlast),
        .o_m_user    (m_tuser)
    );

endmodule

// File: design/lcca_chk.sv
// ----------------------------------------------------------------------------
// lcca_chk - port checker for the load cell calibrated averager
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module lcca_chk import lcca_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  m_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Mid-run results carry no averages and no flag.
    a_mid_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> (m_tdata[127:32] == 96'd0) && !m_tuser)
        else $error("mid-run result carries run fields");

    // The undefined flag only ends a run, with the percent cleared.
    a_undef_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[127:96] == 32'd0))
        else $error("undefined percent not cleared");

    // One item at a time: input closes after each transfer.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input open right after a transfer");

endmodule

bind load_cell_calibrated_averager lcca_chk u_chk (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - load cell calibrated averager
// Plays whole calibration runs (begin-run, samples with rising elapsed time,
// a run-ending sample, stray samples after the end) under several register
// settings. A scoreboard predicts the weight and the end-of-run figures for
// every sample that the block acts on and compares each returned field in order.
// ----------------------------------------------------------------------------
module testbench;
    import lcca_pkg::*;

    localparam int              SECS_CEIL     = 60;
    localparam int              MS_IN_SEC     = 1000;
    localparam longint          WORD_HI       = 64'sd2147483647;
    localparam longint          WORD_LO       = -64'sd2147483648;
    localparam longint unsigned TALLY_FULL    = (64'd1 << COUNT_WIDTH) - 1;
    localparam int              ITEM_TARGET   = 1250;
    localparam int              PHASE_ITEMS   = 150;
    localparam int              SETTLE_CYCLES = 300;
    localparam int              HOLD_CYCLES   = 3000;
    localparam int              CYCLE_LIMIT   = 2_000_000;

    typedef struct {
        logic [31:0] weight;
        logic        run_done;
        logic [31:0] mean_raw;
        logic [31:0] mean_weight;
        logic [31:0] pct_error;
        logic        no_reference;
    } t_grams_result;

    // Calibration predictor plus the queue of results still owed by the block
    class calib_scoreboard;
        logic [31:0]     offset_q24;
        logic [31:0]     slope_up;
        logic [31:0]     slope_down;
        logic [5:0]      duration_s;
        logic [31:0]     ref_grams;
        longint unsigned tally;
        longint          raw_total;
        longint          grams_total;
        bit              run_closed;
        t_grams_result   awaited[$];
        int              errors;
        int              checked;
        int              runs_closed;

        function new();
            offset_q24  = 32'd106251056;
            slope_up    = 32'd13667655;
            slope_down  = 32'd13736560;
            duration_s  = 6'd60;
            ref_grams   = 32'd0;
            tally       = 0;
            raw_total   = 0;
            grams_total = 0;
            run_closed  = 0;
            errors      = 0;
            checked     = 0;
            runs_closed = 0;
        endfunction

        // Truncate toward zero, then clamp to the signed 32-bit range
        function longint quot_sat(longint num, longint den);
            longint q;
            q = num / den;
            if (q > WORD_HI) q = WORD_HI;
            if (q < WORD_LO) q = WORD_LO;
            return q;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                CFG_ZERO_OFFSET:      offset_q24 = val;
                CFG_SLOPE_POSITIVE:   slope_up   = val;
                CFG_SLOPE_NEGATIVE:   slope_down = val;
                CFG_RUN_SECONDS:      duration_s = val[5:0];
                CFG_REFERENCE_WEIGHT: ref_grams  = val;
                default: ;
            endcase
        endfunction

        function int threshold_ms();
            int secs;
            secs = duration_s;
            if (secs == 0) secs = 1;
            if (secs > SECS_CEIL) secs = SECS_CEIL;
            return secs * MS_IN_SEC;
        endfunction

        // Note an accepted input transfer; return 1 unless the block ignores it
        function bit note_input(bit op, logic [23:0] raw_bits, logic [15:0] ms);
            longint        raw;
            longint        delta;
            longint        slope;
            longint        grams;
            longint        n;
            longint        rw;
            longint        a;
            longint        r;
            longint        num;
            longint        mean_w;
            t_grams_result res;
            if (op) begin
                tally       = 0;
                raw_total   = 0;
                grams_total = 0;
                run_closed  = 0;
                return 1;
            end
            if (run_closed) return 0;

            raw   = $signed(raw_bits);
            delta = raw * 256 - longint'($signed(offset_q24));
            slope = (delta >= 0) ? longint'(slope_up) : longint'(slope_down);
            if (slope == 0) slope = 1;
            grams = quot_sat(delta * 16777216, slope);

            // A full counter still reports the weight but stops accumulating
            if (tally < TALLY_FULL) begin
                tally++;
                raw_total   += raw;
                grams_total += grams;
            end

            res.weight       = grams[31:0];
            res.run_done     = (int'(ms) >= threshold_ms());
            res.mean_raw     = '0;
            res.mean_weight  = '0;
            res.pct_error    = '0;
            res.no_reference = 1'b0;

            if (res.run_done) begin
                n          = (tally == 0) ? 1 : longint'(tally);
                rw         = $signed(ref_grams);
                run_closed = 1;
                num        = quot_sat(raw_total * 256, n);
                res.mean_raw = num[31:0];
                mean_w     = quot_sat(grams_total, n);
                res.mean_weight = mean_w[31:0];
                if (rw == 0) begin
                    res.no_reference = 1'b1;
                end else begin
                    a   = (mean_w < 0) ? -mean_w : mean_w;
                    r   = (rw < 0) ? -rw : rw;
                    num = (a - r) * 100 * 65536;
                    num = quot_sat((rw < 0) ? -num : num, r);
                    res.pct_error = num[31:0];
                end
            end
            awaited.push_back(res);
            return 1;
        endfunction

        function void match_field(string label, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic last, logic user);
            t_grams_result want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got tdata %h tlast %b",
                         $time, data, last);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (want.run_done) runs_closed++;
            match_field("weight", want.weight, data[31:0]);
            match_field("run_done", {31'd0, want.run_done}, {31'd0, last});
            match_field("average_raw", want.mean_raw, data[63:32]);
            match_field("average_weight", want.mean_weight, data[95:64]);
            match_field("percent_error", want.pct_error, data[127:96]);
            match_field("error_undefined", {31'd0, want.no_reference}, {31'd0, user});
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [31:0]           i_cfg_data;

    calib_scoreboard sb;
    bit              calm;       // suppress random idling on both sides
    bit              hold_req;   // ask the receiver for one long hold-off
    int              effective;  // input transfers that the block acted on
    int              offered;    // input transfers of any kind
    int              settings;
    int              cycle_count;

    load_cell_calibrated_averager dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Check every result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 7);
            end
        end
    end

    // Give up if the run stops making progress
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timed out after %0d cycles, %0d results still owed",
                 $time, cycle_count, sb.awaited.size());
        $display("status: fail");
        $finish;
    end

    // Offer one transfer, idling first now and then; valid stays high afterwards
    task automatic offer(bit op, logic [23:0] raw, logic [15:0] ms);
        while (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {ms, raw};
        do @(posedge i_clk); while (!s_tready);
        offered++;
        if (sb.note_input(op, raw, ms)) effective++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic apply_settings(logic [31:0] ofs, logic [31:0] up, logic [31:0] down,
                                  logic [5:0] secs, logic [31:0] refw);
        write_reg(CFG_ZERO_OFFSET, ofs);
        write_reg(CFG_SLOPE_POSITIVE, up);
        write_reg(CFG_SLOPE_NEGATIVE, down);
        write_reg(CFG_RUN_SECONDS, {26'd0, secs});
        write_reg(CFG_REFERENCE_WEIGHT, refw);
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // Drop valid, drain the results, then let any ignored work finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Raw count: full random, a rail, or close to the current zero offset
    function automatic logic [23:0] pick_raw();
        longint centre;
        int     jitter;
        case ($urandom_range(7))
            0, 1: return 24'($urandom);
            2:    return $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
            default: begin
                jitter = $urandom_range(4000);
                centre = longint'($signed(sb.offset_q24)) / 256 + jitter - 2000;
                if (centre > 8388607) centre = 8388607;
                if (centre < -8388608) centre = -8388608;
                return centre[23:0];
            end
        endcase
    endfunction

    task automatic random_settings();
        logic [31:0] ofs;
        logic [31:0] up;
        logic [31:0] down;
        logic [31:0] refw;
        logic [23:0] base;
        base = 24'($urandom);
        ofs  = $urandom_range(1) ? $urandom : {base, 8'($urandom)};
        up   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0010_0000, 32'h0400_0000);
        down = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0010_0000, 32'h0400_0000);
        case ($urandom_range(4))
            0:       refw = '0;
            1:       refw = $urandom;
            default: begin
                refw = $urandom_range(1, 32'h0FFF_FFFF);
                if ($urandom_range(1)) refw = -refw;
            end
        endcase
        apply_settings(ofs, up, down, 6'($urandom_range(63)), refw);
    endtask

    // One calibration run: begin, samples below the deadline, the closing
    // sample, then stray samples that must be ignored. Break a few on purpose.
    task automatic play_run();
        int          lead;
        int          k;
        int          limit_ms;
        int          step;
        int          ms;
        logic [23:0] junk;
        limit_ms = sb.threshold_ms();
        lead     = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(1, 8);
        step     = (limit_ms - 1) / (lead + 1);
        junk     = 24'($urandom);
        if ($urandom_range(19) != 0) offer(1'b1, junk, 16'($urandom));
        ms = 0;
        for (k = 0; k < lead; k++) begin
            ms = ms + $urandom_range(step);
            if ($urandom_range(24) == 0) offer(1'b1, pick_raw(), 16'($urandom));
            if ($urandom_range(29) == 0) offer(1'b0, pick_raw(), 16'($urandom));
            else                         offer(1'b0, pick_raw(), 16'(ms));
        end
        if ($urandom_range(3) == 0) ms = limit_ms;
        else                        ms = $urandom_range(limit_ms, 65535);
        offer(1'b0, pick_raw(), 16'(ms));
        repeat ($urandom_range(2)) offer(1'b0, pick_raw(), 16'($urandom));
    endtask

    initial begin
        int  next_phase;
        bit  hold_used;
        sb          = new();
        calm        = 1'b0;
        hold_req    = 1'b0;
        hold_used   = 1'b0;
        effective   = 0;
        offered     = 0;
        settings    = 0;
        cycle_count = 0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_ZERO_OFFSET;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration, zero reference: rails, deadline edges, stray sample
        offer(1'b1, 24'hFF_FFFF, 16'hFFFF);
        offer(1'b0, 24'h7F_FFFF, 16'h0000);
        offer(1'b0, 24'h80_0000, 16'd59999);
        offer(1'b0, 24'd415043, 16'd60000);
        offer(1'b0, 24'h00_0000, 16'hFFFF);
        offer(1'b1, 24'h00_0000, 16'h0000);
        offer(1'b0, 24'h00_0000, 16'hFFFF);
        settle();

        // Zero positive slope, zero duration taken as one second
        apply_settings(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 6'd0, 32'h0001_0000);
        offer(1'b1, 24'h00_0000, 16'h0000);
        offer(1'b0, 24'h00_0001, 16'd999);
        offer(1'b0, 24'hFF_FFFF, 16'd1000);
        settle();

        // Largest offset and slopes, duration above the ceiling, most negative reference
        apply_settings(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 32'h8000_0000);
        offer(1'b1, 24'h00_0000, 16'h0000);
        offer(1'b0, 24'h00_0000, 16'd59999);
        offer(1'b0, 24'h7F_FFFF, 16'd60000);
        settle();

        // Most negative offset, unit slopes: weights and percent saturate
        apply_settings(32'h8000_0000, 32'h0000_0001, 32'h0000_0001, 6'd1, 32'h0000_0001);
        offer(1'b1, 24'h00_0000, 16'h0000);
        offer(1'b0, 24'h00_0005, 16'h0000);
        offer(1'b0, 24'h80_0000, 16'd1000);
        offer(1'b0, 24'h00_007B, 16'd5);
        settle();

        // Unequal slopes either side of zero, negative reference
        apply_settings(32'h0000_0000, 32'h0001_0000, 32'h0002_0000, 6'd60, 32'hFF9C_0000);
        offer(1'b1, 24'h00_0000, 16'h0000);
        offer(1'b0, 24'h00_0064, 16'd100);
        offer(1'b0, 24'hFF_FF9C, 16'd60000);
        settle();

        // Random runs under a fresh calibration every so often
        next_phase = effective;
        while (offered < ITEM_TARGET) begin
            if (effective >= next_phase) begin
                settle();
                random_settings();
                next_phase = effective + PHASE_ITEMS;
            end
            calm = (effective >= 400 && effective < 600);
            if (!hold_used && effective >= 800) begin
                hold_req  = 1'b1;
                hold_used = 1'b1;
            end
            play_run();
        end
        calm = 1'b0;
        settle();

        $display("%0d transfers offered, %0d acted on under %0d calibration settings",
                 offered, effective, settings);
        $display("%0d results checked, %0d runs closed, %0d mismatches",
                 sb.checked, sb.runs_closed, sb.errors);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
design/lcca_pkg.sv
design/lcca_div.sv
design/lcca_dp.sv
design/lcca_ctrl.sv
design/load_cell_calibrated_averager.sv
design/lcca_chk.sv
sim/testbench.sv
